### hw/rtl/jcond_pkg.sv
// Shared types and constants for the joystick conditioner with trim.
`default_nettype none

package jcond_pkg;

  localparam int unsigned NUM_CH      = 4;
  localparam int unsigned RAW_W       = 12;
  localparam int unsigned VAL_W       = 10;
  localparam int unsigned STEP_W      = 7;
  localparam int unsigned KEY_W       = 3;
  localparam int unsigned SCALE_MAX   = 1000;
  localparam int unsigned RAW_FULL    = 4095;
  localparam int unsigned REST_MID    = 500;
  localparam int unsigned CAL_SAMPLES = 10;
  localparam int unsigned STEP_RESET  = 10;

  // Item kinds
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_KEY    = 1'b1;

  // Key codes
  localparam logic [KEY_W-1:0] KEY_NONE        = 3'd0;
  localparam logic [KEY_W-1:0] KEY_TRIM_UP     = 3'd1;
  localparam logic [KEY_W-1:0] KEY_TRIM_DOWN   = 3'd2;
  localparam logic [KEY_W-1:0] KEY_TRIM_LEFT   = 3'd3;
  localparam logic [KEY_W-1:0] KEY_TRIM_RIGHT  = 3'd4;
  localparam logic [KEY_W-1:0] KEY_SHUTDOWN    = 3'd5;
  localparam logic [KEY_W-1:0] KEY_HOLD_HEIGHT = 3'd6;
  localparam logic [KEY_W-1:0] KEY_CALIBRATE   = 3'd7;

  typedef logic [NUM_CH-1:0][RAW_W-1:0] raw_arr_t;
  typedef logic [NUM_CH-1:0][VAL_W-1:0] val_arr_t;

  typedef struct packed {
    logic             kind;
    logic [RAW_W-1:0] throttle_raw;
    logic [RAW_W-1:0] yaw_raw;
    logic [RAW_W-1:0] roll_raw;
    logic [RAW_W-1:0] pitch_raw;
    logic [KEY_W-1:0] key_code;
  } in_item_t;

  typedef struct packed {
    logic [VAL_W-1:0] throttle_out;
    logic [VAL_W-1:0] yaw_out;
    logic [VAL_W-1:0] roll_out;
    logic [VAL_W-1:0] pitch_out;
    logic             sample_valid;
    logic             shutdown_request;
    logic             hold_height_request;
    logic             calibrating;
  } out_item_t;

  // Scaled item held between input register and state update
  typedef struct packed {
    logic             kind;
    val_arr_t         scaled;
    logic [KEY_W-1:0] key_code;
  } stage_t;

endpackage

`default_nettype wire

### hw/rtl/jcond_scale.sv
// Inverting scale of one 12-bit reading to 0..1000.
`default_nettype none

module jcond_scale (
  input  wire logic [jcond_pkg::RAW_W-1:0] raw,
  output logic      [jcond_pkg::VAL_W-1:0] scaled
);
  import jcond_pkg::*;

  localparam int unsigned PROD_W = RAW_W + VAL_W;

  logic [PROD_W-1:0] prod;
  logic [VAL_W-1:0]  q_hi;
  logic [RAW_W:0]    rem;
  logic [VAL_W-1:0]  quot;

  // Divide raw*1000 by 4096-1: high part plus one correction step
  always_comb begin
    prod = PROD_W'(raw) * PROD_W'(SCALE_MAX);
    q_hi = prod[PROD_W-1:RAW_W];
    rem  = {1'b0, prod[RAW_W-1:0]} + (RAW_W+1)'(q_hi);
    quot = (rem >= (RAW_W+1)'(RAW_FULL)) ? q_hi + VAL_W'(1) : q_hi;
    scaled = VAL_W'(SCALE_MAX) - quot;
  end

endmodule

`default_nettype wire

### hw/rtl/jcond_state.sv
// Bias, trim and calibration state with the per-item update and result.
`default_nettype none

module jcond_state (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         adv,
  input  wire jcond_pkg::stage_t            stage,
  input  wire logic [jcond_pkg::STEP_W-1:0] trim_step,
  output jcond_pkg::out_item_t              result
);
  import jcond_pkg::*;

  localparam int unsigned V_W         = 18;
  localparam int unsigned DIV10_MUL   = 205;
  localparam int unsigned DIV10_SHIFT = 11;
  localparam logic [7:0]  REST_LOW    = 8'(REST_MID);

  // Signed divide by ten, truncated toward zero, for an 8-bit value
  function automatic logic [7:0] div10(input logic [7:0] s);
    logic [8:0]  mag;
    logic [16:0] prod;
    logic [5:0]  q;
    mag  = s[7] ? (9'd256 - {1'b0, s}) : {1'b0, s};
    prod = 17'(mag) * 17'(DIV10_MUL);
    q    = 6'(prod >> DIV10_SHIFT);
    return s[7] ? (8'd0 - {2'b00, q}) : {2'b00, q};
  endfunction

  logic [NUM_CH-1:0][7:0] bias, bias_next;
  logic [NUM_CH-1:0][7:0] sums, sums_next;
  logic signed [15:0]     pitch_trim, pitch_trim_next;
  logic signed [15:0]     roll_trim, roll_trim_next;
  logic [3:0]             cal_count, cal_count_next;
  logic                   cal_active, cal_active_next;
  val_arr_t               val;
  logic                   shutdown, hold;

  // Apply bias and trim, then clamp each channel
  always_comb begin
    logic signed [V_W-1:0] v;
    logic signed [V_W-1:0] trim_add;
    for (int c = 0; c < NUM_CH; c++) begin
      trim_add = '0;
      if (c == 2) trim_add = V_W'(roll_trim);
      if (c == 3) trim_add = V_W'(pitch_trim);
      v = $signed({8'd0, stage.scaled[c]}) - V_W'($signed(bias[c])) + trim_add;
      if (v < 0) begin
        val[c] = '0;
      end else if (v > $signed(V_W'(SCALE_MAX))) begin
        val[c] = VAL_W'(SCALE_MAX);
      end else begin
        val[c] = v[VAL_W-1:0];
      end
    end
  end

  // Next state for samples and key events
  always_comb begin
    logic [3:0] cnt_inc;
    bias_next       = bias;
    sums_next       = sums;
    pitch_trim_next = pitch_trim;
    roll_trim_next  = roll_trim;
    cal_count_next  = cal_count;
    cal_active_next = cal_active;
    shutdown        = 1'b0;
    hold            = 1'b0;
    cnt_inc         = cal_count + 4'd1;
    if (stage.kind == KIND_SAMPLE) begin
      if (cal_active) begin
        for (int c = 0; c < NUM_CH; c++) begin
          sums_next[c] = sums[c] + val[c][7:0] - ((c == 0) ? 8'd0 : REST_LOW);
        end
        cal_count_next = cnt_inc;
        if (cnt_inc >= 4'(CAL_SAMPLES)) begin
          for (int c = 0; c < NUM_CH; c++) begin
            bias_next[c] = bias[c] + div10(sums_next[c]);
          end
          cal_active_next = 1'b0;
          cal_count_next  = '0;
        end
      end
    end else if (!cal_active) begin
      unique case (stage.key_code)
        KEY_NONE: ;
        KEY_TRIM_UP:     pitch_trim_next = pitch_trim + 16'(trim_step);
        KEY_TRIM_DOWN:   pitch_trim_next = pitch_trim - 16'(trim_step);
        KEY_TRIM_LEFT:   roll_trim_next  = roll_trim - 16'(trim_step);
        KEY_TRIM_RIGHT:  roll_trim_next  = roll_trim + 16'(trim_step);
        KEY_SHUTDOWN:    shutdown = 1'b1;
        KEY_HOLD_HEIGHT: hold     = 1'b1;
        KEY_CALIBRATE: begin
          pitch_trim_next = '0;
          roll_trim_next  = '0;
          sums_next       = '0;
          cal_count_next  = '0;
          cal_active_next = 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Hold state; advance it once per processed item
  always_ff @(posedge clk) begin
    if (rst) begin
      bias       <= '0;
      sums       <= '0;
      pitch_trim <= '0;
      roll_trim  <= '0;
      cal_count  <= '0;
      cal_active <= 1'b0;
    end else if (adv) begin
      bias       <= bias_next;
      sums       <= sums_next;
      pitch_trim <= pitch_trim_next;
      roll_trim  <= roll_trim_next;
      cal_count  <= cal_count_next;
      cal_active <= cal_active_next;
    end
  end

  // Form the result item
  always_comb begin
    result = '0;
    if (stage.kind == KIND_SAMPLE) begin
      result.throttle_out = val[0];
      result.yaw_out      = val[1];
      result.roll_out     = val[2];
      result.pitch_out    = val[3];
      result.sample_valid = 1'b1;
    end
    result.shutdown_request    = shutdown;
    result.hold_height_request = hold;
    result.calibrating         = cal_active_next;
  end

endmodule

`default_nettype wire

### hw/rtl/joystick_conditioner_with_trim_unit.sv
// Joystick conditioner with key trims and bias calibration: top level.
//
// Usage: an item on in_item is either a stick sample (kind 0, four 12-bit
// readings) or a key event (kind 1, key_code). Each accepted item yields
// exactly one result item on out_item, in order. Both channels use
// valid/ready; cfg_valid/cfg_ready writes trim_step (cfg_ready is always
// high); the user must write it only while the block is idle; the block itself does not enforce this.
// An accepted item is scaled into the input register, then passes to the
// result register, where out_valid rises. Throughput: one item per cycle
// while the receiver does not stall. The first register holds the scaled
// readings; the bias, trim and calibration state updates together with the
// result register, so each item sees the state left by the one before.
// Reset clears trims, biases and calibration and sets trim_step to 10.
// When the receiver stalls, the result register holds its item, the input
// register fills, and in_ready drops until out_ready returns.
`default_nettype none

module joystick_conditioner_with_trim_unit (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire jcond_pkg::in_item_t          in_item,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output jcond_pkg::out_item_t              out_item,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [jcond_pkg::STEP_W-1:0] cfg_data
);
  import jcond_pkg::*;

  logic              st_valid;
  stage_t            stage;
  stage_t            stage_next;
  raw_arr_t          raw_arr;
  val_arr_t          scaled_arr;
  logic              adv;
  logic [STEP_W-1:0] trim_step;
  out_item_t         result;

  assign adv       = st_valid && (!out_valid || out_ready);
  assign in_ready  = !st_valid || adv;
  assign cfg_ready = 1'b1;

  // Scale the four readings on the way in
  assign raw_arr = {in_item.pitch_raw, in_item.roll_raw, in_item.yaw_raw,
                    in_item.throttle_raw};

  for (genvar c = 0; c < NUM_CH; c++) begin : g_scale
    jcond_scale u_scale (
      .raw    (raw_arr[c]),
      .scaled (scaled_arr[c])
    );
  end

  always_comb begin
    stage_next.kind     = in_item.kind;
    stage_next.scaled   = scaled_arr;
    stage_next.key_code = in_item.key_code;
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      st_valid <= 1'b1;
    end else if (adv) begin
      st_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage <= stage_next;
    end
  end

  // Trim step register
  always_ff @(posedge clk) begin
    if (rst) begin
      trim_step <= STEP_W'(STEP_RESET);
    end else if (cfg_valid && cfg_ready) begin
      trim_step <= cfg_data;
    end
  end

  jcond_state u_state (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .stage     (stage),
    .trim_step (trim_step),
    .result    (result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_item <= result;
    end
  end

  // A processed sample shows up next cycle as a sample result
  a_sample_flows: assert property (@(posedge clk) disable iff (rst)
    adv && stage.kind == KIND_SAMPLE |=> out_valid && out_item.sample_valid)
    else $error("sample item did not produce a sample result");

  // A key result carries zero channels
  a_key_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_item.sample_valid |->
      out_item.throttle_out == '0 && out_item.yaw_out == '0 &&
      out_item.roll_out == '0 && out_item.pitch_out == '0)
    else $error("key result carries channel values");

  // Channels stay within full scale
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |->
      out_item.throttle_out <= VAL_W'(SCALE_MAX) && out_item.yaw_out <= VAL_W'(SCALE_MAX) &&
      out_item.roll_out <= VAL_W'(SCALE_MAX) && out_item.pitch_out <= VAL_W'(SCALE_MAX))
    else $error("channel value above full scale");

  // Requests only from key events outside calibration
  a_request: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_item.shutdown_request || out_item.hold_height_request) |->
      !out_item.sample_valid && !out_item.calibrating &&
      !(out_item.shutdown_request && out_item.hold_height_request))
    else $error("request raised outside an idle key event");

  // Input register never overflows
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    st_valid && !adv |-> !in_ready)
    else $error("input register overwritten");

endmodule

`default_nettype wire

### verif/joystick_conditioner_with_trim_unit_tb.sv
// Self-checking testbench for the joystick conditioner with trim unit.
`default_nettype none

module joystick_conditioner_with_trim_unit_tb;
  import jcond_pkg::*;

  localparam int unsigned ITEMS_PER_PHASE = 271;
  localparam int unsigned NUM_PHASES      = 6;
  localparam int unsigned LONG_HOLD       = 150;
  localparam int unsigned MAX_REPORTS     = 10;

  typedef struct {
    in_item_t  stim;
    bit        typed;
    out_item_t want;
  } vector_row_t;

  logic                clk;
  logic                rst       = 1'b1;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  in_item_t            in_item   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  out_item_t           out_item;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [STEP_W-1:0]   cfg_data  = '0;

  // Predicted block state, starting from the reset values
  logic [STEP_W-1:0]   trim_step  = STEP_W'(STEP_RESET);
  logic signed [7:0]   ch_bias [NUM_CH] = '{default: '0};
  logic [15:0]         pitch_trim = '0;
  logic [15:0]         roll_trim  = '0;
  logic [7:0]          cal_sum [NUM_CH] = '{default: '0};
  logic [3:0]          cal_count  = '0;
  logic                cal_on     = 1'b0;

  out_item_t           pending_results [$];
  int unsigned         fail_count    = 0;
  bit                  send_idle_on  = 1'b0;
  bit                  sink_idle_on  = 1'b0;
  bit                  hold_off_req  = 1'b0;

  joystick_conditioner_with_trim_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Condition one accepted item and advance the predicted state
  function automatic out_item_t condition_item(input in_item_t it);
    out_item_t        r;
    logic [RAW_W-1:0] raw [NUM_CH];
    int               v [NUM_CH];
    int               q;
    r      = '0;
    raw[0] = it.throttle_raw;
    raw[1] = it.yaw_raw;
    raw[2] = it.roll_raw;
    raw[3] = it.pitch_raw;
    if (it.kind == KIND_SAMPLE) begin
      // Scale and invert, remove bias, add trims, clamp at full width
      for (int c = 0; c < NUM_CH; c++) begin
        v[c] = int'(SCALE_MAX) - int'(raw[c]) * int'(SCALE_MAX) / int'(RAW_FULL);
        v[c] -= int'(ch_bias[c]);
        if (c == 2) v[c] += int'($signed(roll_trim));
        if (c == 3) v[c] += int'($signed(pitch_trim));
        if (v[c] < 0) v[c] = 0;
        if (v[c] > int'(SCALE_MAX)) v[c] = int'(SCALE_MAX);
      end
      r.throttle_out = VAL_W'(v[0]);
      r.yaw_out      = VAL_W'(v[1]);
      r.roll_out     = VAL_W'(v[2]);
      r.pitch_out    = VAL_W'(v[3]);
      r.sample_valid = 1'b1;
      // Accumulate deviations from rest; fold into the biases on the tenth
      if (cal_on) begin
        for (int c = 0; c < NUM_CH; c++)
          cal_sum[c] = cal_sum[c] + 8'(v[c] - (c == 0 ? 0 : int'(REST_MID)));
        cal_count = cal_count + 4'd1;
        if (cal_count >= CAL_SAMPLES) begin
          for (int c = 0; c < NUM_CH; c++) begin
            q          = int'($signed(cal_sum[c])) / int'(CAL_SAMPLES);
            ch_bias[c] = ch_bias[c] + 8'(q);
          end
          cal_on    = 1'b0;
          cal_count = '0;
        end
      end
    end else if (!cal_on) begin
      case (it.key_code)
        KEY_TRIM_UP:     pitch_trim = pitch_trim + 16'(trim_step);
        KEY_TRIM_DOWN:   pitch_trim = pitch_trim - 16'(trim_step);
        KEY_TRIM_LEFT:   roll_trim  = roll_trim - 16'(trim_step);
        KEY_TRIM_RIGHT:  roll_trim  = roll_trim + 16'(trim_step);
        KEY_SHUTDOWN:    r.shutdown_request = 1'b1;
        KEY_HOLD_HEIGHT: r.hold_height_request = 1'b1;
        KEY_CALIBRATE: begin
          pitch_trim = '0;
          roll_trim  = '0;
          for (int c = 0; c < NUM_CH; c++) cal_sum[c] = '0;
          cal_count  = '0;
          cal_on     = 1'b1;
        end
        default: ;
      endcase
    end
    r.calibrating = cal_on;
    return r;
  endfunction

  function automatic in_item_t sample_of(input int unsigned t, input int unsigned y,
                                         input int unsigned r, input int unsigned p);
    in_item_t it;
    it              = '0;
    it.kind         = KIND_SAMPLE;
    it.throttle_raw = RAW_W'(t);
    it.yaw_raw      = RAW_W'(y);
    it.roll_raw     = RAW_W'(r);
    it.pitch_raw    = RAW_W'(p);
    return it;
  endfunction

  function automatic in_item_t key_of(input logic [KEY_W-1:0] code);
    in_item_t it;
    it          = '0;
    it.kind     = KIND_KEY;
    it.key_code = code;
    return it;
  endfunction

  function automatic out_item_t result_of(input int unsigned t, input int unsigned y,
                                          input int unsigned r, input int unsigned p,
                                          input bit sv, input bit sd, input bit hh,
                                          input bit cal);
    out_item_t o;
    o.throttle_out        = VAL_W'(t);
    o.yaw_out             = VAL_W'(y);
    o.roll_out            = VAL_W'(r);
    o.pitch_out           = VAL_W'(p);
    o.sample_valid        = sv;
    o.shutdown_request    = sd;
    o.hold_height_request = hh;
    o.calibrating         = cal;
    return o;
  endfunction

  function automatic logic [RAW_W-1:0] pick_raw();
    case ($urandom_range(0, 3))
      0:       return $urandom_range(0, 1) ? RAW_W'(RAW_FULL) : '0;
      1:       return RAW_W'($urandom_range(1897, 2197));
      default: return RAW_W'($urandom_range(0, 4095));
    endcase
  endfunction

  // Mostly samples while calibrating, a mix of samples and keys otherwise
  function automatic in_item_t next_random_item();
    in_item_t it;
    it.throttle_raw = pick_raw();
    it.yaw_raw      = pick_raw();
    it.roll_raw     = pick_raw();
    it.pitch_raw    = pick_raw();
    it.key_code     = KEY_W'($urandom_range(0, 7));
    if (cal_on)
      it.kind = ($urandom_range(0, 9) == 0) ? KIND_KEY : KIND_SAMPLE;
    else
      it.kind = ($urandom_range(0, 99) < 35) ? KIND_KEY : KIND_SAMPLE;
    return it;
  endfunction

  function automatic string show(input out_item_t r);
    return $sformatf("thr=%0d yaw=%0d roll=%0d pitch=%0d valid=%b shut=%b hold=%b cal=%b",
                     r.throttle_out, r.yaw_out, r.roll_out, r.pitch_out, r.sample_valid,
                     r.shutdown_request, r.hold_height_request, r.calibrating);
  endfunction

  // Offer one item, predict it at acceptance, then maybe idle for a burst
  task automatic deliver(input in_item_t it, input bit typed, input out_item_t want);
    out_item_t   pred;
    int unsigned gap;
    in_item  <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    pred = condition_item(it);
    pending_results.push_back(typed ? want : pred);
    @(negedge clk);
    if (send_idle_on && $urandom_range(0, 5) == 0) begin
      gap      = $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Stop sending and wait for every outstanding result, plus pipeline slack
  task automatic drain();
    in_valid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_trim_step(input logic [STEP_W-1:0] value);
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    trim_step = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Receiver: random stall bursts, plus one long hold-off on request
  initial begin : result_sink
    int unsigned stall;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready    <= 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
      end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
        stall     = $urandom_range(1, 12);
        out_ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Capture each accepted result and compare it with the oldest prediction
  initial begin : result_check
    out_item_t got;
    out_item_t want;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        got = out_item;
        @(negedge clk);
        if (pending_results.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("unexpected result: %s", show(got));
        end else begin
          want = pending_results.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS) begin
              $display("result mismatch");
              $display("  expected %s", show(want));
              $display("  actual   %s", show(got));
            end
          end
        end
      end
    end
  end

  initial begin : watchdog
    #4000000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin : stimulus
    vector_row_t       rows [$];
    logic [STEP_W-1:0] step_plan [NUM_PHASES];

    // Directed rows at reset trim step
    rows.push_back('{sample_of(0, 0, 0, 0), 1'b1, result_of(1000, 1000, 1000, 1000, 1, 0, 0, 0)});
    rows.push_back('{sample_of(4095, 4095, 4095, 4095), 1'b1, result_of(0, 0, 0, 0, 1, 0, 0, 0)});
    rows.push_back('{key_of(KEY_NONE), 1'b1, result_of(0, 0, 0, 0, 0, 0, 0, 0)});
    rows.push_back('{key_of(KEY_TRIM_UP), 1'b0, '0});
    rows.push_back('{key_of(KEY_TRIM_DOWN), 1'b0, '0});
    rows.push_back('{key_of(KEY_TRIM_DOWN), 1'b0, '0});
    rows.push_back('{key_of(KEY_TRIM_LEFT), 1'b0, '0});
    rows.push_back('{key_of(KEY_TRIM_RIGHT), 1'b0, '0});
    rows.push_back('{key_of(KEY_TRIM_RIGHT), 1'b0, '0});
    rows.push_back('{key_of(KEY_SHUTDOWN), 1'b1, result_of(0, 0, 0, 0, 0, 1, 0, 0)});
    rows.push_back('{key_of(KEY_HOLD_HEIGHT), 1'b1, result_of(0, 0, 0, 0, 0, 0, 1, 0)});
    // Trims push past both clamp limits
    rows.push_back('{sample_of(0, 0, 0, 4095), 1'b0, '0});
    rows.push_back('{sample_of(2048, 2048, 4095, 0), 1'b0, '0});
    // Long press starts calibration; keys inside it are dropped
    rows.push_back('{key_of(KEY_CALIBRATE), 1'b1, result_of(0, 0, 0, 0, 0, 0, 0, 1)});
    rows.push_back('{key_of(KEY_TRIM_UP), 1'b1, result_of(0, 0, 0, 0, 0, 0, 0, 1)});
    rows.push_back('{key_of(KEY_SHUTDOWN), 1'b1, result_of(0, 0, 0, 0, 0, 0, 0, 1)});
    // Ten calibration samples; the last one ends calibration
    rows.push_back('{sample_of(2047, 2047, 2047, 2047), 1'b0, '0});
    rows.push_back('{sample_of(0, 0, 0, 0), 1'b0, '0});
    rows.push_back('{sample_of(4095, 4095, 4095, 4095), 1'b0, '0});
    rows.push_back('{sample_of(100, 3000, 1500, 2600), 1'b0, '0});
    rows.push_back('{sample_of(4000, 1900, 2200, 2047), 1'b0, '0});
    rows.push_back('{sample_of(3900, 2100, 1950, 2150), 1'b0, '0});
    rows.push_back('{sample_of(4095, 2047, 2047, 2047), 1'b0, '0});
    rows.push_back('{sample_of(2500, 1000, 3000, 500), 1'b0, '0});
    rows.push_back('{sample_of(4095, 2000, 2100, 1990), 1'b0, '0});
    rows.push_back('{sample_of(3800, 2047, 2047, 2200), 1'b0, '0});

    step_plan[0] = STEP_W'(100);
    step_plan[1] = '0;
    step_plan[2] = STEP_W'($urandom_range(0, 100));
    step_plan[3] = STEP_W'(1);
    step_plan[4] = STEP_W'($urandom_range(0, 100));
    step_plan[5] = STEP_W'(100);

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst          <= 1'b0;
    send_idle_on = 1'b1;
    sink_idle_on = 1'b1;

    foreach (rows[i]) deliver(rows[i].stim, rows[i].typed, rows[i].want);

    // Random phases, each at its own trim step and idle pattern
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain();
      write_trim_step(step_plan[ph]);
      send_idle_on = (ph != 1) && (ph != NUM_PHASES - 1);
      sink_idle_on = (ph != 2) && (ph != NUM_PHASES - 1);
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        if (ph == 1 && k == 60) hold_off_req = 1'b1;
        deliver(next_random_item(), 1'b0, '0);
      end
    end

    drain();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
